// ----- sv/b64sd_pkg.sv -----
// Shared types, constants and the character decode function for the base64 stream decoder.
package b64sd_pkg;

    localparam int unsigned MAX_OUT_BYTES_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH_DEF   = 4;

    localparam int unsigned COUNT_W = 13;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_DONE      = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_BAD_CHAR  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    // One queued unit of work: the bytes of a finished group and an optional end status.
    typedef struct packed {
        logic [23:0]        bytes;
        logic [1:0]         nbytes;
        logic               last;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_job;

    // Returns {valid, sextet}; valid is low for anything outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ----- sv/b64sd_front.sv -----
// Front end: accepts characters, builds groups, tracks errors and queues output work.
module b64sd_front
    import b64sd_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_final_char,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_job       o_job
);

    localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1);
    localparam logic [CNT_W:0] MAX_W = (CNT_W + 1)'(MAX_OUT_BYTES);

    logic [23:0]      r_group, n_group;
    logic [1:0]       r_chars, n_chars;
    logic [2:0]       r_pad, n_pad;
    logic [CNT_W-1:0] r_bytes_out, n_bytes_out;
    t_err             r_err, n_err;

    logic                 accept;
    logic [6:0]           sx;
    logic [1:0]           nb;
    logic [CNT_W:0]       sum;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    t_job                 job;

    assign accept     = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;

    always_comb begin
        sx          = sextet_of(i_char_in);
        n_group     = r_group;
        n_pad       = r_pad;
        n_err       = r_err;
        n_bytes_out = r_bytes_out;
        job         = '0;
        job.status  = ST_DATA;

        if (r_err == ERR_NONE) begin
            if (i_char_in == CHAR_PAD) begin
                n_pad   = r_pad + 3'd1;
                n_group = {r_group[17:0], 6'd0};
            end else if (sx[6]) begin
                n_group = {r_group[17:0], sx[5:0]};
            end else begin
                n_err = ERR_BAD_CHAR;
            end
        end

        n_chars = r_chars + 2'd1;
        nb      = (n_pad >= 3'd3) ? 2'd0 : 2'(3'd3 - n_pad);
        sum     = {1'b0, r_bytes_out} + (CNT_W + 1)'(nb);
        job.bytes = n_group;

        if (n_chars == 2'd0) begin
            if (n_err == ERR_NONE) begin
                if (sum > MAX_W) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    job.nbytes  = nb;
                    n_bytes_out = sum[CNT_W-1:0];
                end
            end
            n_group = '0;
            n_pad   = '0;
        end

        count_ext = {{COUNT_W{1'b0}}, n_bytes_out};
        job.last  = i_final_char;
        if (i_final_char) begin
            job.count = count_ext[COUNT_W-1:0];
            // A short final group overrides any sticky error.
            if (n_chars != 2'd0) begin
                job.status = ST_BAD_LEN;
            end else begin
                unique case (n_err)
                    ERR_BAD_CHAR: job.status = ST_BAD_CHAR;
                    ERR_OVERFLOW: job.status = ST_OVERFLOW;
                    default:      job.status = ST_DONE;
                endcase
            end
        end
    end

    assign o_push = accept && (job.nbytes != 2'd0 || i_final_char);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars     <= '0;
            r_pad       <= '0;
            r_bytes_out <= '0;
            r_err       <= ERR_NONE;
        end else if (accept) begin
            if (i_final_char) begin
                r_chars     <= '0;
                r_pad       <= '0;
                r_bytes_out <= '0;
                r_err       <= ERR_NONE;
            end else begin
                r_chars     <= n_chars;
                r_pad       <= n_pad;
                r_bytes_out <= n_bytes_out;
                r_err       <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
        end else if (accept) begin
            r_group <= i_final_char ? 24'd0 : n_group;
        end
    end

`ifndef NO_ASSERTIONS
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final_char) |=> (r_chars == 2'd0 && r_pad == 3'd0
            && r_bytes_out == '0 && r_err == ERR_NONE))
        else $error("state not cleared after final character");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_final_char && r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("sticky error changed within a string");

    a_pad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad <= {1'b0, r_chars}) && ({1'b0, r_bytes_out} <= MAX_W))
        else $error("pad count or byte count out of range");
`endif

endmodule

// ----- sv/b64sd_queue.sv -----
// Short work queue between the front end and the output sequencer.
module b64sd_queue
    import b64sd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/b64sd_back.sv -----
// Output sequencer: plays each queued job out as one result per transfer.
module b64sd_back
    import b64sd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_job               i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_data_byte,
    output logic [2:0]         o_status,
    output logic [COUNT_W-1:0] o_decoded_count,
    output logic               o_run_end
);

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic [2:0] total;
    logic       is_last;
    logic       is_status;

    assign total     = {1'b0, r_job.nbytes} + {2'b0, r_job.last};
    assign is_last   = ({1'b0, r_idx} == total - 3'd1);
    assign is_status = (r_idx == r_job.nbytes);
    assign o_pop     = i_q_valid && (!r_busy || (i_out_ready && is_last));

    always_comb begin
        o_data_byte     = 8'd0;
        o_status        = ST_DATA;
        o_decoded_count = '0;
        if (is_status) begin
            o_status        = r_job.status;
            o_decoded_count = r_job.count;
        end else begin
            unique case (r_idx)
                2'd0:    o_data_byte = r_job.bytes[23:16];
                2'd1:    o_data_byte = r_job.bytes[15:8];
                default: o_data_byte = r_job.bytes[7:0];
            endcase
        end
    end

    assign o_out_valid = r_busy;
    assign o_run_end   = is_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_out_ready) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DATA) |-> o_run_end)
        else $error("end status not marked as last result");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DATA) |-> (o_decoded_count == '0))
        else $error("data result carries a count");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < total))
        else $error("result index past end of job");
`endif

endmodule

// ----- sv/base64_stream_decoder.sv -----
// A character's results pass through the work queue and the sequencer's job register.
// Throughput: one character per cycle in; one result per cycle out while the output is
// ready, so four characters (up to three bytes plus an end status) pass without stall.
// A four-entry work queue decouples input from output; input stalls only when it fills.
// Reset (synchronous, active low) clears group state, counters, errors and the queue.
module base64_stream_decoder
    import b64sd_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_in,
    input  logic               i_final_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_data_byte,
    output logic [2:0]         o_status,
    output logic [COUNT_W-1:0] o_decoded_count,
    output logic               o_run_end
);

    logic q_ready, q_valid, push, pop;
    t_job push_job, pop_job;

    b64sd_front #(
        .MAX_OUT_BYTES(MAX_OUT_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .i_q_ready    (q_ready),
        .o_push       (push),
        .o_job        (push_job)
    );

    b64sd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_job)
    );

    b64sd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (pop_job),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_status        (o_status),
        .o_decoded_count (o_decoded_count),
        .o_run_end       (o_run_end)
    );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for base64_stream_decoder with a scoreboard class and random idling.
module testbench;
    import b64sd_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0]         data;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               run_end;
    } t_b64_result;

    class t_b64_scoreboard;
        t_b64_result owed[$];
        int          mismatches;
        logic [23:0] grp;
        logic [1:0]  phase;
        int          pads;
        int          bytes_done;
        t_err        err;

        function new();
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            grp        = '0;
            phase      = '0;
            pads       = 0;
            bytes_done = 0;
            err        = ERR_NONE;
        endfunction

        function int sextet(logic [7:0] c);
            for (int k = 0; k < 64; k++) begin
                if (B64_ALPHABET[k] == c) return k;
            end
            return -1;
        endfunction

        function void owe(logic [7:0] d, t_status st, int cnt, logic last);
            t_b64_result r;
            r.data    = d;
            r.status  = st;
            r.count   = COUNT_W'(cnt);
            r.run_end = last;
            owed.push_back(r);
        endfunction

        // Work out every result that one accepted character causes.
        function void note_char(logic [7:0] c, logic fin);
            int      v;
            int      nb;
            t_status end_st;
            if (err == ERR_NONE) begin
                if (c == CHAR_PAD) begin
                    pads++;
                    grp = {grp[17:0], 6'd0};
                end else begin
                    v = sextet(c);
                    if (v < 0) begin
                        err = ERR_BAD_CHAR;
                    end else begin
                        grp = {grp[17:0], 6'(v)};
                    end
                end
            end
            phase = phase + 2'd1;
            if (phase == 2'd0) begin
                if (err == ERR_NONE) begin
                    nb = (pads >= 3) ? 0 : 3 - pads;
                    if (bytes_done + nb > MAX_OUT_BYTES_DEF) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        for (int j = 0; j < nb; j++) begin
                            owe(grp[(2 - j) * 8 +: 8], ST_DATA, 0, (j == nb - 1) && !fin);
                        end
                        bytes_done += nb;
                    end
                end
                grp  = '0;
                pads = 0;
            end
            if (fin) begin
                if (phase != 2'd0) begin
                    end_st = ST_BAD_LEN;
                end else if (err == ERR_BAD_CHAR) begin
                    end_st = ST_BAD_CHAR;
                end else if (err == ERR_OVERFLOW) begin
                    end_st = ST_OVERFLOW;
                end else begin
                    end_st = ST_DONE;
                end
                owe(8'd0, end_st, bytes_done, 1'b1);
                clear_run();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [7:0] d, logic [2:0] st, logic [COUNT_W-1:0] cnt,
                          logic last);
            t_b64_result e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result status %0d byte %02h", st, d));
                return;
            end
            e = owed.pop_front();
            if (d !== e.data)
                report($sformatf("data byte %02h, want %02h", d, e.data));
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (cnt !== e.count)
                report($sformatf("decoded count %0d, want %0d", cnt, e.count));
            if (last !== e.run_end)
                report($sformatf("run end %0b, want %0b", last, e.run_end));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_in;
    logic               final_char;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         data_byte;
    logic [2:0]         status;
    logic [COUNT_W-1:0] decoded_count;
    logic               run_end;
    logic               calm;
    int                 cycles;
    t_b64_scoreboard    sb;

    base64_stream_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_char_in       (char_in),
        .i_final_char    (final_char),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_data_byte     (data_byte),
        .o_status        (status),
        .o_decoded_count (decoded_count),
        .o_run_end       (run_end)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Check each output transfer, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(data_byte, status, decoded_count, run_end);
        out_ready <= calm || ($urandom_range(99) >= 8);
    end

    function automatic logic [7:0] pick_b64();
        return B64_ALPHABET[$urandom_range(63)];
    endfunction

    task automatic send_char(logic [7:0] c, logic fin);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        char_in    <= c;
        final_char <= fin;
        do @(posedge i_clk); while (!in_ready);
        sb.note_char(c, fin);
    endtask

    task automatic send_text(string s, logic fin);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], fin && (k == s.len() - 1));
    endtask

    task automatic send_random_string(output int n);
        logic [7:0] txt[$];
        int         sel;
        int         len;
        int         pads;
        sel = $urandom_range(99);
        if (sel < 85) begin
            len  = 4 * $urandom_range(1, 4);
            pads = ($urandom_range(9) == 0) ? $urandom_range(3, 4) : $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                if (k >= len - pads || $urandom_range(39) == 0)
                    txt.push_back(CHAR_PAD);
                else
                    txt.push_back(pick_b64());
            end
            // corrupt one position with an arbitrary byte
            if (sel >= 70)
                txt[$urandom_range(len - 1)] = 8'($urandom_range(255));
        end else if (sel < 95) begin
            len = $urandom_range(1, 11);
            for (int k = 0; k < len; k++)
                txt.push_back(($urandom_range(5) == 0) ? CHAR_PAD : pick_b64());
        end else begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                txt.push_back(8'($urandom_range(255)));
        end
        foreach (txt[k])
            send_char(txt[k], k == txt.size() - 1);
        n = txt.size();
    endtask

    initial begin
        int random_sent;
        int n;
        sb         = new();
        i_clk      = 1'b0;
        i_rst_n    <= 1'b0;
        in_valid   <= 1'b0;
        char_in    <= 8'd0;
        final_char <= 1'b0;
        out_ready  <= 1'b0;
        calm       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("+/Az09Q=", 1'b1);
        send_text("Q=======", 1'b1);
        send_text("Q=QU", 1'b0);
        send_char(8'h00, 1'b0);
        send_text("AAA", 1'b1);
        send_char(CHAR_PAD, 1'b0);
        send_char(8'hFF, 1'b1);

        // Run a stretch with no idling on either side.
        random_sent = 0;
        calm <= 1'b1;
        while (random_sent < 35) begin
            send_random_string(n);
            random_sent += n;
        end
        calm <= 1'b0;

        while (random_sent < 75) begin
            send_random_string(n);
            random_sent += n;
        end
        in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
